[rtl/raf_pkg.sv]
//------------------------------------------------------------------------------
// Running average filter package
// Shared widths, constants, handshake structs and a helper function.
//------------------------------------------------------------------------------
`default_nettype none

package raf_pkg;

	localparam int MAX_WINDOW   = 32;
	localparam int SAMPLE_BITS  = 16;
	localparam int AVG_BITS     = 16;
	localparam int WINDOW_BITS  = 6;
	localparam int SUM_BITS     = 22;
	localparam int SLOT_BITS    = $clog2(MAX_WINDOW);
	localparam int COUNT_BITS   = $clog2(MAX_WINDOW + 1);
	localparam int REM_BITS     = COUNT_BITS + 1;
	localparam int DIV_STEPS    = SUM_BITS;
	localparam int STEP_BITS    = $clog2(DIV_STEPS);

	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(20);

	// Request to the divider: magnitude of the sum, fill count, sign.
	typedef struct packed {
		logic                   start;
		logic                   neg;
		logic [SUM_BITS-1:0]    magnitude;
		logic [COUNT_BITS-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                   busy;
		logic                   done;
		logic [AVG_BITS-1:0]    quotient;
	} div_rsp_t;

	// Map the register value onto the window actually used.
	function automatic logic [COUNT_BITS-1:0] win_eff(input logic [WINDOW_BITS-1:0] w);
		logic [COUNT_BITS-1:0] r;
		if (w == '0) begin
			r = COUNT_BITS'(1);
		end else if (int'(w) > MAX_WINDOW) begin
			r = COUNT_BITS'(MAX_WINDOW);
		end else begin
			r = COUNT_BITS'(w);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/raf_if.sv]
//------------------------------------------------------------------------------
// Running average filter channel interfaces
// Valid/ready channels for samples, averages and the window register write.
//------------------------------------------------------------------------------
`default_nettype none

interface raf_sample_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [raf_pkg::SAMPLE_BITS-1:0]   sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface raf_average_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [raf_pkg::AVG_BITS-1:0]      average;

	modport source (output valid, output average, input ready);
	modport sink (input valid, input average, output ready);
endinterface

interface raf_cfg_if;
	logic                                     valid;
	logic                                     ready;
	logic [raf_pkg::WINDOW_BITS-1:0]          window_size;

	modport source (output valid, output window_size, input ready);
	modport sink (input valid, input window_size, output ready);
endinterface

`default_nettype wire

[rtl/running_average_filter.sv]
//------------------------------------------------------------------------------
// Running average filter
// Moving average over the most recent window_size samples.
//------------------------------------------------------------------------------
// Each sample transaction is folded into a ring of up to 32 samples and a
// running sum, and one average transaction comes out per sample: the sum over
// the samples held so far divided by how many are held (up to the window),
// truncated toward zero. The ring is read at acceptance; then sum and ring are
// updated, the divide is launched, the bit-serial divider works one quotient
// bit per cycle over the 22-bit sum, its finish is seen, and the output
// register is loaded. The next sample is accepted in the cycle after the
// average is loaded, even while that average still waits downstream, so a
// new sample is not taken until the previous average is in the output
// register. A window_size write (0 acts as 1, above 32 acts as 32) empties
// the filter at once; there is no clearing pass, since ring entries not yet
// written since the last clear are treated as zero.
//------------------------------------------------------------------------------
`default_nettype none

module running_average_filter (
	input  wire logic       clk,
	input  wire logic       arst_n,
	raf_sample_if.sink      smp,
	raf_average_if.source   avg,
	raf_cfg_if.sink         cfg
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_UPD   = 5'b00010,
		S_START = 5'b00100,
		S_WAIT  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t                                  state_q;
	logic [raf_pkg::WINDOW_BITS-1:0]         window_q;
	logic signed [raf_pkg::SUM_BITS-1:0]     sum_q;
	logic [raf_pkg::SLOT_BITS-1:0]           slot_q;
	logic [raf_pkg::COUNT_BITS-1:0]          count_q;
	logic signed [raf_pkg::SAMPLE_BITS-1:0]  sample_q;
	logic signed [raf_pkg::SAMPLE_BITS-1:0]  rd_q;
	logic signed [raf_pkg::AVG_BITS-1:0]     avg_q;
	logic                                    out_valid_q;

	// Sample ring, written in the update cycle, read at acceptance
	logic [raf_pkg::SAMPLE_BITS-1:0]         ring_mem [raf_pkg::MAX_WINDOW];

	logic [raf_pkg::COUNT_BITS-1:0]          win;
	logic [raf_pkg::SLOT_BITS-1:0]           slot_use;
	logic [raf_pkg::COUNT_BITS-1:0]          slot_inc;
	logic [raf_pkg::SLOT_BITS-1:0]           slot_next;
	logic                                    filling;
	logic signed [raf_pkg::SAMPLE_BITS-1:0]  old_val;
	logic signed [raf_pkg::SUM_BITS-1:0]     sum_next;
	logic                                    smp_take;
	logic                                    avg_take;
	logic                                    out_load;
	raf_pkg::div_req_t                       div_req;
	raf_pkg::div_rsp_t                       div_rsp;

	always_comb begin
		win = raf_pkg::win_eff(window_q);
		// Wrap a slot that lies past the window before using it
		slot_use  = (raf_pkg::COUNT_BITS'(slot_q) >= win) ? '0 : slot_q;
		slot_inc  = raf_pkg::COUNT_BITS'(slot_use) + raf_pkg::COUNT_BITS'(1);
		slot_next = (slot_inc >= win) ? '0 : slot_inc[raf_pkg::SLOT_BITS-1:0];
		// While the ring fills, the slot being replaced was never written since
		// the last clear, so treat it as zero
		filling   = (count_q < win);
		old_val   = filling ? '0 : rd_q;
		sum_next  = sum_q - raf_pkg::SUM_BITS'(old_val)
		            + raf_pkg::SUM_BITS'(sample_q);
	end

	assign smp.ready = (state_q == S_IDLE);
	assign smp_take  = smp.valid && smp.ready;
	assign avg_take  = avg.valid && avg.ready;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || avg.ready);
	assign cfg.ready = 1'b1;

	// Launch the divide on the updated sum; the divider works on the magnitude
	always_comb begin
		div_req.start     = (state_q == S_START);
		div_req.neg       = sum_q[raf_pkg::SUM_BITS-1];
		div_req.magnitude = sum_q[raf_pkg::SUM_BITS-1] ? raf_pkg::SUM_BITS'(-sum_q)
		                                                : raf_pkg::SUM_BITS'(sum_q);
		div_req.divisor   = count_q;
	end

	raf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			window_q <= raf_pkg::WINDOW_RESET;
			sum_q    <= '0;
			slot_q   <= '0;
			count_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (smp_take) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					// Drop the oldest sample, add the new one, advance the slot
					sum_q   <= sum_next;
					slot_q  <= slot_next;
					if (filling) begin
						count_q <= count_q + raf_pkg::COUNT_BITS'(1);
					end
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// Hold until the output register is free
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A window write empties the filter
			if (cfg.valid && cfg.ready) begin
				window_q <= cfg.window_size;
				sum_q    <= '0;
				slot_q   <= '0;
				count_q  <= '0;
			end
		end
	end

	// Capture the sample and read the slot it replaces
	always_ff @(posedge clk) begin
		if (smp_take) begin
			sample_q <= smp.sample;
			rd_q     <= ring_mem[slot_use];
		end
		if (state_q == S_UPD) begin
			ring_mem[slot_use] <= sample_q;
		end
	end

	// Output register: parts the sequencer from the downstream ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (avg_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_q <= div_rsp.quotient;
		end
	end

	assign avg.valid   = out_valid_q;
	assign avg.average = avg_q;

	// The divider is never busy while a new sample can be taken
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		smp.ready |-> !div_rsp.busy)
		else $error("sample accepted while divider busy");

	// The fill count never passes the active window
	a_count_win: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= win)
		else $error("fill count beyond window");

	// A quotient only completes while the sequencer waits for it
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_WAIT))
		else $error("divider finished outside wait state");

	// The output register is loaded only when it is free or being drained
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !avg.ready && state_q == S_OUT) |=> (state_q == S_OUT))
		else $error("pending average overwritten");

endmodule

`default_nettype wire

[rtl/raf_div.sv]
//------------------------------------------------------------------------------
// Running average filter divider
// Bit-serial restoring divider, one quotient bit per cycle, signed result.
//------------------------------------------------------------------------------
`default_nettype none

module raf_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire raf_pkg::div_req_t  req,
	output raf_pkg::div_rsp_t       rsp
);

	logic [raf_pkg::SUM_BITS-1:0]   work_q;
	logic [raf_pkg::COUNT_BITS-1:0] rem_q;
	logic [raf_pkg::COUNT_BITS-1:0] div_q;
	logic [raf_pkg::STEP_BITS-1:0]  cnt_q;
	logic                           neg_q;
	logic                           busy_q;
	logic                           done_q;

	logic [raf_pkg::REM_BITS-1:0]   rem_shift;
	logic [raf_pkg::REM_BITS-1:0]   div_ext;
	logic                           ge;
	logic [raf_pkg::REM_BITS-1:0]   rem_next;
	logic [raf_pkg::SUM_BITS-1:0]   quot_signed;

	always_comb begin
		rem_shift   = {rem_q, work_q[raf_pkg::SUM_BITS-1]};
		div_ext     = {1'b0, div_q};
		ge          = (rem_shift >= div_ext);
		rem_next    = ge ? (rem_shift - div_ext) : rem_shift;
		quot_signed = neg_q ? (~work_q + raf_pkg::SUM_BITS'(1)) : work_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + raf_pkg::STEP_BITS'(1);
			if (cnt_q == raf_pkg::STEP_BITS'(raf_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: shift the dividend out, shift quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.magnitude;
			rem_q  <= '0;
			div_q  <= req.divisor;
			neg_q  <= req.neg;
		end else if (busy_q) begin
			work_q <= {work_q[raf_pkg::SUM_BITS-2:0], ge};
			// The remainder stays below the divisor, so it fits the count width
			rem_q  <= rem_next[raf_pkg::COUNT_BITS-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quot_signed[raf_pkg::AVG_BITS-1:0];

endmodule

`default_nettype wire
